// ===== rtl/sidiv_pkg.sv =====
package sidiv_pkg;

    localparam int WIDTH_DEF = 32;

    // datapath commands issued by the controller
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

endpackage

// ===== rtl/sidiv_ctrl.sv =====
module sidiv_ctrl #(
    parameter int WIDTH = sidiv_pkg::WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sidiv_pkg::t_dp_cmd o_cmd
);
    import sidiv_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(WIDTH - 1);
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // wait until the output register can take the result
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/sidiv_dp.sv =====
module sidiv_dp #(
    parameter int WIDTH = sidiv_pkg::WIDTH_DEF
) (
    input  logic               i_clk,
    input  sidiv_pkg::t_dp_cmd i_cmd,
    input  logic [WIDTH-1:0]   i_dividend,
    input  logic [WIDTH-1:0]   i_divisor,
    output logic [WIDTH-1:0]   o_quotient
);
    import sidiv_pkg::*;

    localparam logic [WIDTH-1:0] MIN_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

    logic [WIDTH-1:0] r_num;   // dividend bits shift out, quotient bits shift in
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_den;
    logic             r_neg;
    logic             r_sat;
    logic [WIDTH-1:0] r_q;

    logic [WIDTH-1:0] w_mag_a;
    logic [WIDTH-1:0] w_mag_b;
    logic [WIDTH-1:0] w_shift;
    logic [WIDTH:0]   w_trial;
    logic             w_fits;

    assign w_mag_a = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_b = i_divisor[WIDTH-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // remainder stays below the divisor, so the shifted value fits in WIDTH bits
    assign w_shift = {r_rem[WIDTH-2:0], r_num[WIDTH-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_den};
    assign w_fits  = !w_trial[WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= w_mag_a;
            r_den <= w_mag_b;
            r_rem <= '0;
            r_neg <= i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
            r_sat <= (i_divisor == '0) ||
                     ((i_dividend == MIN_NEG) && (i_divisor == '1));
        end else if (i_cmd.step) begin
            r_rem <= w_fits ? w_trial[WIDTH-1:0] : w_shift;
            r_num <= {r_num[WIDTH-2:0], w_fits};
        end
        if (i_cmd.finish) begin
            if (r_sat) begin
                r_q <= MAX_POS;
            end else if (r_neg) begin
                r_q <= ~r_num + 1'b1;
            end else begin
                r_q <= r_num;
            end
        end
    end

    assign o_quotient = r_q;

endmodule

// ===== rtl/signed_int_divider_saturating.sv =====
// signed integer divider with saturation
//
// input stream: one request carries dividend and divisor; accepted when
// i_s_axis_tvalid and o_s_axis_tready are both high. output stream: one
// quotient per request, truncated toward zero.
// a zero divisor, and the most negative value over minus one, both give the
// largest positive value.
//
// steps: the request is taken in the idle state, then the radix-2 restoring
// loop (one quotient bit per cycle through the shared subtractor), then the
// sign fix and saturation into the output register, once that register is free.
// one request is worked on at a time; the next one is taken while a result
// still waits in the output register.
//
// reset clears the controller and the output valid; no result is pending.
// when the receiver stalls, the result holds in the output register and a
// following division waits at its last step until the register frees up.
module signed_int_divider_saturating #(
    parameter int WIDTH = sidiv_pkg::WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // dividend, divisor
    input  logic [((2*WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // quotient
    output logic [((WIDTH+7)/8)*8-1:0]        o_m_axis_tdata
);
    import sidiv_pkg::*;

    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    t_dp_cmd          w_cmd;
    logic [WIDTH-1:0] w_quotient;

    sidiv_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sidiv_dp #(
        .WIDTH(WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_dividend (i_s_axis_tdata[WIDTH-1:0]),
        .i_divisor  (i_s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_quotient (w_quotient)
    );

    assign o_m_axis_tdata = OUT_W'(w_quotient);

endmodule

// ===== tb/signed_int_divider_saturating_checker.sv =====
`timescale 1ns / 1ps

module signed_int_divider_saturating_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // dividend, divisor
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // quotient
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int W = sidiv_pkg::WIDTH_DEF;

    logic [W-1:0] quotient_q[$];
    int           n_results;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        n_results    = 0;
    end

    // truncated signed quotient, saturating on zero divisor and on min / -1
    function automatic logic [W-1:0] quotient_of(logic [W-1:0] num, logic [W-1:0] den);
        logic         num_neg;
        logic         den_neg;
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W:0]   rem;
        logic [W-1:0] quo;
        num_neg = num[W-1];
        den_neg = den[W-1];
        if (den == '0 || (num == {1'b1, {(W-1){1'b0}}} && den == '1)) begin
            return {1'b0, {(W-1){1'b1}}};
        end
        num_mag = num_neg ? -num : num;
        den_mag = den_neg ? -den : den;
        rem = '0;
        quo = '0;
        for (int i = W - 1; i >= 0; i--) begin
            rem = {rem[W-1:0], num_mag[i]};
            if (rem >= {1'b0, den_mag}) begin
                rem    = rem - {1'b0, den_mag};
                quo[i] = 1'b1;
            end
        end
        return (num_neg != den_neg) ? -quo : quo;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 n_results, what, got, want);
        o_fail_count <= o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        logic [W-1:0] want;
        if (i_rst_n) begin
            // check the output first so a stray result cannot match a fresh request
            if (i_m_tvalid && i_m_tready) begin
                if (quotient_q.size() == 0) begin
                    report_mismatch("unexpected quotient", i_m_tdata[W-1:0], '0);
                end else begin
                    want = quotient_q.pop_front();
                    if (i_m_tdata[W-1:0] !== want)
                        report_mismatch("quotient", i_m_tdata[W-1:0], want);
                end
                n_results++;
            end
            if (i_s_tvalid && i_s_tready)
                quotient_q.push_back(quotient_of(i_s_tdata[W-1:0], i_s_tdata[2*W-1:W]));
            o_pending <= quotient_q.size();
        end
    end

endmodule

// ===== tb/signed_int_divider_saturating_tb.sv =====
`timescale 1ns / 1ps

module signed_int_divider_saturating_tb;

    localparam int W          = sidiv_pkg::WIDTH_DEF;
    localparam int N_RANDOM   = 830;
    localparam int N_QUIET    = 120;
    localparam int MAX_CYCLES = 400000;

    localparam logic [W-1:0] INT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MINUS1  = '1;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    logic        quiet;
    int          cycles;

    signed_int_divider_saturating i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    signed_int_divider_saturating_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > MAX_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: bursts of ready and stall, always ready in the quiet part
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            if (!quiet) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end
        end
    end

    task automatic send_request(logic [W-1:0] dividend, logic [W-1:0] divisor);
        s_tdata  <= {divisor, dividend};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 1;
                    2: return MINUS1;
                    3: return INT_MIN;
                    default: return INT_MAX;
                endcase
            end
            1, 2: return W'($urandom_range(0, 600)) - W'(300);
            3: return W'($urandom) >> $urandom_range(0, W - 1);
            default: return W'($urandom);
        endcase
    endfunction

    initial begin
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        quiet    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero divisor, overflow, signs
        send_request(0, 1);
        send_request(1, 0);
        send_request(0, 0);
        send_request(MINUS1, 0);
        send_request(INT_MIN, 0);
        send_request(INT_MAX, 0);
        send_request(INT_MIN, MINUS1);
        send_request(INT_MIN, 1);
        send_request(INT_MAX, 1);
        send_request(INT_MAX, MINUS1);
        send_request(INT_MAX, INT_MAX);
        send_request(INT_MIN, INT_MIN);
        send_request(INT_MIN, INT_MAX);
        send_request(INT_MAX, INT_MIN);
        send_request(1, INT_MIN);
        send_request(7, 2);
        send_request(-W'(7), 2);
        send_request(7, -W'(2));
        send_request(-W'(7), -W'(2));
        send_request(5, 7);
        send_request(INT_MIN, 2);
        send_request(INT_MIN, -W'(2));
        send_request(MINUS1, MINUS1);
        send_request(100, -W'(3));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until the divider has drained
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            if (n == N_RANDOM - N_QUIET)
                quiet = 1'b1;
            dividend = pick_operand();
            divisor  = pick_operand();
            case ($urandom_range(0, 19))
                0: divisor = '0;
                1: begin
                    dividend = INT_MIN;
                    divisor  = MINUS1;
                end
                default: ;
            endcase
            send_request(dividend, divisor);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
